@@ hw/rtl/crc_pkg.sv @@
package crc_pkg;

    // Field widths
    localparam int IdxW   = 32;
    localparam int ShiftW = 6;
    localparam int LenW   = 48;
    localparam int PosW   = LenW + 1;
    localparam int WideW  = IdxW + 1 + (2 ** ShiftW) - 1;

    // Register reset values
    localparam logic [ShiftW-1:0] ShiftRst = 6'd21;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_CHUNK_SHIFT    = 1'b0,
        CFG_ARTIFACT_BYTES = 1'b1
    } cfg_reg_t;

    // One cell of the sorting row
    typedef struct packed {
        logic            vld;
        logic [IdxW-1:0] val;
    } cell_t;

    // Row command: insert the broadcast key, or shift everything towards the head
    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctl_t;

    // One result item
    typedef struct packed {
        logic [LenW-1:0] range_offset;
        logic [LenW-1:0] range_length;
        logic [IdxW-1:0] first_chunk;
        logic [IdxW-1:0] final_chunk;
        logic            range_valid;
        logic            overflow;
        logic            last_range;
    } res_t;

    typedef enum logic [4:0] {
        S_COLLECT = 5'b00001,
        S_SCAN    = 5'b00010,
        S_SHIFT   = 5'b00100,
        S_CLIP    = 5'b01000,
        S_FLUSH   = 5'b10000
    } state_t;

    // Byte position x << s, saturated to all ones once it reaches 2^48.
    // Anything at or above 2^48 lies beyond every artifact size.
    function automatic logic [PosW-1:0] sat_pos(input logic [IdxW:0] x,
                                                input logic [ShiftW-1:0] s);
        logic [WideW-1:0] w;
        w = {{(WideW-IdxW-1){1'b0}}, x} << s;
        return (|w[WideW-1:LenW]) ? {PosW{1'b1}} : {1'b0, w[LenW-1:0]};
    endfunction

endpackage

@@ hw/rtl/crc_if.sv @@
interface crc_item_if;
    import crc_pkg::*;

    logic            valid;
    logic            ready;
    logic [IdxW-1:0] chunk_index;
    logic            last_index;

    modport source (output valid, output chunk_index, output last_index, input ready);
    modport sink   (input valid, input chunk_index, input last_index, output ready);
endinterface

interface crc_result_if;
    import crc_pkg::*;

    logic            valid;
    logic            ready;
    logic [LenW-1:0] range_offset;
    logic [LenW-1:0] range_length;
    logic [IdxW-1:0] first_chunk;
    logic [IdxW-1:0] final_chunk;
    logic            range_valid;
    logic            overflow;
    logic            last_range;

    modport source (output valid, output range_offset, output range_length,
                    output first_chunk, output final_chunk, output range_valid,
                    output overflow, output last_range, input ready);
    modport sink   (input valid, input range_offset, input range_length,
                    input first_chunk, input final_chunk, input range_valid,
                    input overflow, input last_range, output ready);
endinterface

interface crc_cfg_if;
    import crc_pkg::*;

    logic            valid;
    logic            ready;
    cfg_reg_t        index;
    logic [LenW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/crc_cell.sv @@
module crc_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  crc_pkg::cell_ctl_t        ctl,
    input  logic [crc_pkg::IdxW-1:0]  key,
    input  crc_pkg::cell_t            left,
    input  logic                      left_lt,
    input  crc_pkg::cell_t            right,
    output crc_pkg::cell_t            cur,
    output logic                      lt,
    output logic                      eq
);
    import crc_pkg::*;

    logic            vld_reg, vld_next;
    logic [IdxW-1:0] val_reg, val_next;

    assign cur = '{vld: vld_reg, val: val_reg};

    // Compare against the broadcast key; empty cells never match
    assign lt = vld_reg && (val_reg < key);
    assign eq = vld_reg && (val_reg == key);

    // Insert: smaller entries stay, the boundary cell takes the key,
    // the rest take the left neighbour. Pop: take the right neighbour.
    always_comb
    begin
        vld_next = vld_reg;
        val_next = val_reg;
        if (ctl.ins && !lt)
        begin
            if (left_lt)
            begin
                vld_next = 1'b1;
                val_next = key;
            end
            else
            begin
                vld_next = left.vld;
                val_next = left.val;
            end
        end
        else if (ctl.pop)
        begin
            vld_next = right.vld;
            val_next = right.val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

@@ hw/rtl/chunk_range_coalescer.sv @@
// Collects chunk indices, one item per cycle, into a row of MAX_CHUNKS
// sorting cells that keep them ascending and drop duplicates; a distinct
// index arriving when the row is full is dropped and flags overflow on every
// result of that list. Once the item marked last_index is taken, the row
// shifts its entries out through the head cell, one per cycle while a run
// lasts, merging consecutive indices into runs; each run then goes on to a
// step that sees that the run has ended, the offset shift, then the clip to
// artifact_bytes, and a flush step ends the list. A finished range may wait
// on a stalled result channel, and from the last item until the list is
// closed no input is taken.
// Ranges clipped to zero length are skipped; if none remain, one result with
// range_valid clear is given. Results pass through an output register, so a
// new list may start while the final result still waits to be taken.
module chunk_range_coalescer #(
    parameter int MAX_CHUNKS = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    crc_item_if.sink   src,
    crc_result_if.source dst,
    crc_cfg_if.sink    cfg
);
    import crc_pkg::*;

    // Sorting row
    cell_t                 cells [MAX_CHUNKS];
    logic [MAX_CHUNKS-1:0] lt_vec;
    logic [MAX_CHUNKS-1:0] eq_vec;
    logic [MAX_CHUNKS-1:0] vld_vec;
    cell_ctl_t             ctl;
    cell_t                 head;
    logic                  dup;
    logic                  full;

    // Control and configuration state
    state_t            state_reg, state_next;
    logic              run_reg, run_next;
    logic              fin_reg, fin_next;
    logic              ovf_reg, ovf_next;
    logic              pend_vld_reg, pend_vld_next;
    logic              out_vld_reg, out_vld_next;
    logic [ShiftW-1:0] shift_reg;
    logic [LenW-1:0]   art_reg;

    // Datapath registers
    logic [IdxW-1:0] lo_reg, lo_next;
    logic [IdxW-1:0] hi_reg, hi_next;
    logic [PosW-1:0] off_reg, off_next;
    logic [PosW-1:0] end_reg, end_next;
    res_t            pend_reg, pend_next;
    res_t            out_reg, out_next;

    logic            accept;
    logic            out_free;
    logic [PosW-1:0] end_clip;
    logic [PosW-1:0] len_c;
    logic            nonempty;
    res_t            new_res;
    res_t            empty_res;

    localparam cell_t CellIdle = '{vld: 1'b0, val: '0};

    // Row of cells, each talking to its two neighbours
    for (genvar g = 0; g < MAX_CHUNKS; g++)
    begin : g_cell
        cell_t left_c;
        cell_t right_c;
        logic  left_lt_c;

        if (g == 0)
        begin : g_first
            assign left_c    = CellIdle;
            assign left_lt_c = 1'b1;
        end
        else
        begin : g_mid
            assign left_c    = cells[g-1];
            assign left_lt_c = lt_vec[g-1];
        end

        if (g == MAX_CHUNKS - 1)
        begin : g_last
            assign right_c = CellIdle;
        end
        else
        begin : g_inner
            assign right_c = cells[g+1];
        end

        crc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .key     (src.chunk_index),
            .left    (left_c),
            .left_lt (left_lt_c),
            .right   (right_c),
            .cur     (cells[g]),
            .lt      (lt_vec[g]),
            .eq      (eq_vec[g])
        );

        assign vld_vec[g] = cells[g].vld;
    end

    assign head = cells[0];
    assign dup  = |eq_vec;
    assign full = vld_vec[MAX_CHUNKS-1];

    // Handshakes
    assign src.ready = (state_reg == S_COLLECT);
    assign accept    = src.valid && src.ready;
    assign out_free  = !out_vld_reg || dst.ready;
    assign cfg.ready = 1'b1;

    assign dst.valid        = out_vld_reg;
    assign dst.range_offset = out_reg.range_offset;
    assign dst.range_length = out_reg.range_length;
    assign dst.first_chunk  = out_reg.first_chunk;
    assign dst.final_chunk  = out_reg.final_chunk;
    assign dst.range_valid  = out_reg.range_valid;
    assign dst.overflow     = out_reg.overflow;
    assign dst.last_range   = out_reg.last_range;

    // Clip the run end to the artifact size and form its length
    assign end_clip = (end_reg < {1'b0, art_reg}) ? end_reg : {1'b0, art_reg};
    assign nonempty = end_clip > off_reg;
    assign len_c    = end_clip - off_reg;

    assign new_res = '{range_offset: off_reg[LenW-1:0],
                       range_length: len_c[LenW-1:0],
                       first_chunk:  lo_reg,
                       final_chunk:  hi_reg,
                       range_valid:  1'b1,
                       overflow:     ovf_reg,
                       last_range:   1'b0};

    assign empty_res = '{range_offset: '0,
                         range_length: '0,
                         first_chunk:  '0,
                         final_chunk:  '0,
                         range_valid:  1'b0,
                         overflow:     ovf_reg,
                         last_range:   1'b1};

    // Sequencer: collect, then scan runs out of the row head
    always_comb
    begin
        state_next    = state_reg;
        run_next      = run_reg;
        fin_next      = fin_reg;
        ovf_next      = ovf_reg;
        pend_vld_next = pend_vld_reg;
        out_vld_next  = out_vld_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        off_next      = off_reg;
        end_next      = end_reg;
        pend_next     = pend_reg;
        out_next      = out_reg;
        ctl           = '0;

        if (out_vld_reg && dst.ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_COLLECT:
            begin
                if (accept)
                begin
                    ctl.ins = !dup && !full;
                    if (!dup && full)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (src.last_index)
                    begin
                        run_next   = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (head.vld)
                begin
                    if (run_reg && ({1'b0, head.val} == ({1'b0, hi_reg} + 33'd1)))
                    begin
                        hi_next = head.val;
                        ctl.pop = 1'b1;
                    end
                    else if (run_reg)
                    begin
                        fin_next   = 1'b0;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        lo_next  = head.val;
                        hi_next  = head.val;
                        run_next = 1'b1;
                        ctl.pop  = 1'b1;
                    end
                end
                else if (run_reg)
                begin
                    fin_next   = 1'b1;
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end

            S_SHIFT:
            begin
                off_next   = sat_pos({1'b0, lo_reg}, shift_reg);
                end_next   = sat_pos({1'b0, hi_reg} + 33'd1, shift_reg);
                state_next = S_CLIP;
            end

            S_CLIP:
            begin
                // A new range pushes the one held back towards the output
                if (!(nonempty && pend_vld_reg && !out_free))
                begin
                    if (nonempty)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_next     = pend_reg;
                            out_vld_next = 1'b1;
                        end
                        pend_next     = new_res;
                        pend_vld_next = 1'b1;
                    end
                    run_next   = 1'b0;
                    state_next = fin_reg ? S_FLUSH : S_SCAN;
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    if (pend_vld_reg)
                    begin
                        out_next            = pend_reg;
                        out_next.last_range = 1'b1;
                    end
                    else
                    begin
                        out_next = empty_res;
                    end
                    out_vld_next  = 1'b1;
                    pend_vld_next = 1'b0;
                    ovf_next      = 1'b0;
                    state_next    = S_COLLECT;
                end
            end

            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_COLLECT;
            run_reg      <= 1'b0;
            fin_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            run_reg      <= run_next;
            fin_reg      <= fin_next;
            ovf_reg      <= ovf_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= ShiftRst;
            art_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CHUNK_SHIFT:    shift_reg <= cfg.data[ShiftW-1:0];
                CFG_ARTIFACT_BYTES: art_reg   <= cfg.data;
                default:            ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        off_reg  <= off_next;
        end_reg  <= end_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    // Occupied cells always form a contiguous block from the head
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_vec & (vld_vec + 1'b1)) == '0)
        else $error("sorting row has a gap");

    // The row is drained before the list is closed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> !head.vld)
        else $error("row not empty at end of list");

    // The overflow flag does not leak into the next list
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && out_free) |=> !ovf_reg)
        else $error("overflow flag not cleared");

    // A result without a range is always the end of its list
    assert property (@(posedge clk) disable iff (!rst_n)
        (dst.valid && !dst.range_valid) |-> dst.last_range)
        else $error("empty result not marked last");

    // An unmarked item never starts emission
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !src.last_index) |=> (state_reg == S_COLLECT))
        else $error("emission started without last index");
`endif

endmodule

@@ tb/range_checker.sv @@
// Watches the item, result and register channels of the coalescer, keeps its
// own sorted copy of the current list, and predicts every range it should give.
module range_checker #(
    parameter int CAP = 64
) (
    input  logic   clk,
    input  logic   rst_n,
    crc_item_if    items,
    crc_result_if  ranges,
    crc_cfg_if     regs,
    output int     fail_count,
    output int     ranges_due
);
    import crc_pkg::*;

    // Predictor state
    logic [IdxW-1:0]   sorted_list[$];
    logic              list_overflow;
    logic [ShiftW-1:0] shift_r;
    logic [LenW-1:0]   art_size_r;
    res_t              pending_ranges[$];
    int                errors;

    // Queue one clipped range; returns 1 if it was not empty
    function automatic int add_range(input logic [IdxW-1:0] lo, input logic [IdxW-1:0] hi);
        logic [127:0] off;
        logic [127:0] fin;
        logic [127:0] len;
        res_t         r;
        off = {96'd0, lo} << shift_r;
        fin = ({96'd0, hi} + 128'd1) << shift_r;
        if (fin > {80'd0, art_size_r})
            fin = {80'd0, art_size_r};
        len = (fin > off) ? fin - off : 128'd0;
        if (len == 128'd0)
            return 0;
        r.range_offset = off[LenW-1:0];
        r.range_length = len[LenW-1:0];
        r.first_chunk  = lo;
        r.final_chunk  = hi;
        r.range_valid  = 1'b1;
        r.overflow     = list_overflow;
        r.last_range   = 1'b0;
        pending_ranges.insert(pending_ranges.size(), r);
        return 1;
    endfunction

    // Take one index into the sorted list; on the marked item, merge and predict
    function automatic void absorb_index(input logic [IdxW-1:0] v, input logic mark);
        int              pos;
        int              n;
        logic [IdxW-1:0] lo;
        logic [IdxW-1:0] hi;
        res_t            r;
        pos = 0;
        while (pos < sorted_list.size() && sorted_list[pos] < v)
            pos++;
        if (!(pos < sorted_list.size() && sorted_list[pos] == v))
        begin
            if (sorted_list.size() >= CAP)
                list_overflow = 1'b1;
            else
                sorted_list.insert(pos, v);
        end
        if (!mark)
            return;
        n = 0;
        if (sorted_list.size() > 0)
        begin
            lo = sorted_list[0];
            hi = sorted_list[0];
            for (int i = 1; i < sorted_list.size(); i++)
            begin
                if ({1'b0, sorted_list[i]} == {1'b0, hi} + 33'd1)
                    hi = sorted_list[i];
                else
                begin
                    n += add_range(lo, hi);
                    lo = sorted_list[i];
                    hi = sorted_list[i];
                end
            end
            n += add_range(lo, hi);
        end
        if (n == 0)
        begin
            // nothing survived clipping: a single empty marker
            r = '0;
            r.overflow   = list_overflow;
            r.last_range = 1'b1;
            pending_ranges.insert(pending_ranges.size(), r);
        end
        else
            pending_ranges[pending_ranges.size() - 1].last_range = 1'b1;
        sorted_list.delete();
        list_overflow = 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Monitor all three channels
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            sorted_list.delete();
            pending_ranges.delete();
            list_overflow = 1'b0;
            shift_r       = ShiftRst;
            art_size_r    = '0;
            errors        = 0;
            fail_count <= 0;
            ranges_due <= 0;
        end
        else
        begin
            // results first: a result never belongs to an item taken at the same edge
            if (ranges.valid && ranges.ready)
            begin
                if (pending_ranges.size() == 0)
                begin
                    $display("%0t: unexpected range item, expected none, got %0h/%0h",
                             $time, ranges.range_offset, ranges.range_length);
                    errors++;
                end
                else
                begin
                    want = pending_ranges.pop_front();
                    check_field("range_offset", 64'(want.range_offset),
                                64'(ranges.range_offset));
                    check_field("range_length", 64'(want.range_length),
                                64'(ranges.range_length));
                    check_field("first_chunk", 64'(want.first_chunk),
                                64'(ranges.first_chunk));
                    check_field("final_chunk", 64'(want.final_chunk),
                                64'(ranges.final_chunk));
                    check_field("range_valid", 64'(want.range_valid),
                                64'(ranges.range_valid));
                    check_field("overflow", 64'(want.overflow), 64'(ranges.overflow));
                    check_field("last_range", 64'(want.last_range),
                                64'(ranges.last_range));
                end
            end

            if (regs.valid && regs.ready)
            begin
                case (regs.index)
                    CFG_CHUNK_SHIFT:    shift_r    = regs.data[ShiftW-1:0];
                    CFG_ARTIFACT_BYTES: art_size_r = regs.data;
                    default:            ;
                endcase
            end

            if (items.valid && items.ready)
                absorb_index(items.chunk_index, items.last_index);

            fail_count <= errors;
            ranges_due <= pending_ranges.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    import crc_pkg::*;

    logic clk;
    logic rst_n;
    bit   stall_on;
    int   fails;
    int   waiting;

    crc_item_if   src_ch();
    crc_result_if res_ch();
    crc_cfg_if    cfg_ch();

    chunk_range_coalescer #(
        .MAX_CHUNKS(64)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .src  (src_ch),
        .dst  (res_ch),
        .cfg  (cfg_ch)
    );

    range_checker #(
        .CAP(64)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (src_ch),
        .ranges    (res_ch),
        .regs      (cfg_ch),
        .fail_count(fails),
        .ranges_due(waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on run time
    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver back-pressure
    always @(posedge clk)
        res_ch.ready <= stall_on ? ($urandom_range(0, 99) >= 9) : 1'b1;

    // Offer one index, with a random gap first
    task automatic send_index(input logic [IdxW-1:0] v, input logic mark);
        while (stall_on && $urandom_range(0, 99) < 9)
        begin
            src_ch.valid <= 1'b0;
            @(posedge clk);
        end
        src_ch.valid       <= 1'b1;
        src_ch.chunk_index <= v;
        src_ch.last_index  <= mark;
        @(posedge clk);
        while (!src_ch.ready)
            @(posedge clk);
    endtask

    // Drain every expected range, then let the block run dry
    task automatic settle();
        src_ch.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Both registers back to back; valid stays high between them
    task automatic set_config(input logic [ShiftW-1:0] sh, input logic [LenW-1:0] sz);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_CHUNK_SHIFT;
        cfg_ch.data  <= {{(LenW-ShiftW){1'b0}}, sh};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.index <= CFG_ARTIFACT_BYTES;
        cfg_ch.data  <= sz;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One list clustered around base, with some far indices and repeats
    task automatic random_list(input logic [IdxW-1:0] base, input int len);
        logic [IdxW-1:0] seen[$];
        logic [IdxW-1:0] v;
        int              c;
        for (int k = 0; k < len; k++)
        begin
            c = $urandom_range(0, 99);
            if (c < 65)
                v = base + $urandom_range(0, 30);
            else if (c < 80 || seen.size() == 0)
                v = $urandom;
            else
                v = seen[$urandom_range(0, seen.size() - 1)];
            seen.insert(seen.size(), v);
            send_index(v, k == len - 1);
        end
    endtask

    // Stimulus
    initial
    begin
        logic [ShiftW-1:0] sh;
        logic [LenW-1:0]   sz;
        logic [IdxW-1:0]   base;
        logic [IdxW-1:0]   v;
        logic [IdxW-1:0]   tmp;
        logic [95:0]       t;
        logic [IdxW-1:0]   pool[$];
        int                len;
        int                j;
        int                phase_items;

        rst_n              <= 1'b0;
        stall_on            = 1'b1;
        src_ch.valid       <= 1'b0;
        src_ch.chunk_index <= '0;
        src_ch.last_index  <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_CHUNK_SHIFT;
        cfg_ch.data        <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: artifact size zero, so the only result is the empty marker
        send_index(32'd5, 1'b1);
        settle();

        // Unit chunks, full artifact: index extremes, duplicate, two runs
        set_config(6'd0, {LenW{1'b1}});
        send_index(32'd0, 1'b0);
        send_index(32'hFFFF_FFFF, 1'b0);
        send_index(32'hFFFF_FFFE, 1'b0);
        send_index(32'd3, 1'b0);
        send_index(32'd3, 1'b0);
        send_index(32'd1, 1'b0);
        send_index(32'd2, 1'b1);
        send_index(32'd9, 1'b1);
        settle();

        // Shift of 40: clipped tail, a range past the end, a hugely shifted index
        set_config(6'd40, (48'd3 << 40) + 48'd123);
        send_index(32'd4, 1'b0);
        send_index(32'd0, 1'b0);
        send_index(32'd2, 1'b0);
        send_index(32'd1, 1'b0);
        send_index(32'd3, 1'b1);
        send_index(32'd10, 1'b0);
        send_index(32'd2, 1'b1);
        send_index(32'hFFFF_FFFF, 1'b1);
        settle();

        // Zero artifact size again with a mid shift
        set_config(6'd12, '0);
        send_index(32'd7, 1'b0);
        send_index(32'd8, 1'b1);
        settle();

        // Random phases, each under its own settings
        for (int p = 0; p < 8; p++)
        begin
            if (p == 0)
                sh = 6'd0;
            else if (p == 1)
                sh = 6'd40;
            else
            begin
                case ($urandom_range(0, 3))
                    0:       sh = 6'd0;
                    1:       sh = 6'd40;
                    default: sh = 6'($urandom_range(0, 40));
                endcase
            end
            // keep the cluster base inside 48-bit byte space when shifts are large
            base = (sh >= 16) ? ($urandom & ((32'd1 << (48 - sh)) - 32'd1)) : $urandom;
            t = ({64'd0, base} + 96'($urandom_range(0, 24))) << sh;
            t = t + ({32'd0, $urandom, $urandom} & ((96'd1 << sh) - 96'd1));
            case ($urandom_range(0, 5))
                0:       sz = '0;
                1:       sz = '1;
                default: sz = ((t >> 48) != 96'd0) ? {LenW{1'b1}} : t[LenW-1:0];
            endcase
            if (p == 0)
                sz = '1;
            set_config(sh, sz);

            // two phases run with no idling on either side
            stall_on = !(p == 4 || p == 5);

            if (p == 4)
            begin
                // More distinct indices than the store holds, shuffled
                pool.delete();
                len = $urandom_range(66, 72);
                v = base;
                for (j = 0; j < len; j++)
                begin
                    v = v + $urandom_range(1, 3);
                    pool.insert(pool.size(), v);
                end
                pool.insert(pool.size(), pool[5]);
                for (j = pool.size() - 1; j > 0; j--)
                begin
                    len = $urandom_range(0, j);
                    tmp = pool[j];
                    pool[j] = pool[len];
                    pool[len] = tmp;
                end
                for (j = 0; j < pool.size(); j++)
                    send_index(pool[j], j == pool.size() - 1);
            end

            phase_items = 0;
            while (phase_items < 10)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
                random_list(base, len);
                phase_items += len;
            end
            settle();
        end

        stall_on = 1'b1;
        if (fails == 0 && waiting == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
